@@ hw/rtl/obb_sat_pkg.sv @@
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Types and constants for the 2D oriented box overlap test core.
// ----------------------------------------------------------------------------
package obb_sat_pkg;

    // Direction fraction bits (Q1.14 cosine and sine)
    localparam int ROT_BITS = 14;

    // Pipeline depth from accepted word to result strobe
    localparam int PIPE_DEPTH = 6;

    // Separating axis codes
    localparam logic [2:0] AXIS_A_U = 3'd0;
    localparam logic [2:0] AXIS_A_V = 3'd1;
    localparam logic [2:0] AXIS_B_U = 3'd2;
    localparam logic [2:0] AXIS_B_V = 3'd3;
    localparam logic [2:0] AXIS_NONE = 3'd4;

    typedef struct packed {
        logic signed [31:0] a_center_x;
        logic signed [31:0] a_center_y;
        logic signed [15:0] a_cos;
        logic signed [15:0] a_sin;
        logic [30:0]        a_half_width;
        logic [30:0]        a_half_height;
        logic signed [31:0] b_center_x;
        logic signed [31:0] b_center_y;
        logic signed [15:0] b_cos;
        logic signed [15:0] b_sin;
        logic [30:0]        b_half_width;
        logic [30:0]        b_half_height;
    } obb_in_t;

    typedef struct packed {
        logic       overlap;
        logic [2:0] separating_axis;
    } obb_out_t;

endpackage

@@ hw/rtl/oriented_box_overlap_test_core.sv @@
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_core
// Separating axis test of two 2D oriented rectangles, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   A box pair word is presented on boxes and taken at a clock edge where
//   start is high and busy is low. busy is always low: a new word may be
//   started in every cycle.
//   Each word yields exactly one result on result, marked by done for one
//   cycle, in order of acceptance. Throughput is one word per cycle; the
//   six register stages are center difference, projection and direction
//   products, sums and magnitudes, cross term products, radius sums,
//   compare and axis pick.
//   Axes are tried A-u, A-v, B-u, B-v; the first separating one is
//   reported, otherwise overlap is set and the axis reads AXIS_NONE.
//   Reset clears the valid bits only; words in flight are dropped.
//   The receiver cannot stall, so no back pressure exists anywhere.
// ----------------------------------------------------------------------------
module oriented_box_overlap_test_core
    import obb_sat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  obb_in_t  boxes,
    output logic     done,
    output obb_out_t result
);

    function automatic logic [48:0] mag50(input logic signed [49:0] v);
        logic signed [49:0] n;
        n = -v;
        return v[49] ? n[48:0] : v[48:0];
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;

    // ---------------- stage 1: center difference ----------------
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [15:0] ac1_reg, as1_reg, bc1_reg, bs1_reg;
    logic [30:0]        ahw1_reg, ahh1_reg, bhw1_reg, bhh1_reg;

    always_ff @(posedge clk)
    begin
        dx_reg   <= 33'(boxes.a_center_x) - 33'(boxes.b_center_x);
        dy_reg   <= 33'(boxes.a_center_y) - 33'(boxes.b_center_y);
        ac1_reg  <= boxes.a_cos;
        as1_reg  <= boxes.a_sin;
        bc1_reg  <= boxes.b_cos;
        bs1_reg  <= boxes.b_sin;
        ahw1_reg <= boxes.a_half_width;
        ahh1_reg <= boxes.a_half_height;
        bhw1_reg <= boxes.b_half_width;
        bhh1_reg <= boxes.b_half_height;
    end

    // ---------------- stage 2: products ----------------
    logic signed [48:0] ac_dx_reg, as_dy_reg, as_dx_reg, ac_dy_reg;
    logic signed [48:0] bc_dx_reg, bs_dy_reg, bs_dx_reg, bc_dy_reg;
    logic signed [31:0] cc_reg, ss_reg, sc_reg, cs_reg;
    logic [30:0]        ahw2_reg, ahh2_reg, bhw2_reg, bhh2_reg;

    always_ff @(posedge clk)
    begin
        ac_dx_reg <= 49'(ac1_reg) * 49'(dx_reg);
        as_dy_reg <= 49'(as1_reg) * 49'(dy_reg);
        as_dx_reg <= 49'(as1_reg) * 49'(dx_reg);
        ac_dy_reg <= 49'(ac1_reg) * 49'(dy_reg);
        bc_dx_reg <= 49'(bc1_reg) * 49'(dx_reg);
        bs_dy_reg <= 49'(bs1_reg) * 49'(dy_reg);
        bs_dx_reg <= 49'(bs1_reg) * 49'(dx_reg);
        bc_dy_reg <= 49'(bc1_reg) * 49'(dy_reg);
        cc_reg    <= 32'(ac1_reg) * 32'(bc1_reg);
        ss_reg    <= 32'(as1_reg) * 32'(bs1_reg);
        sc_reg    <= 32'(as1_reg) * 32'(bc1_reg);
        cs_reg    <= 32'(ac1_reg) * 32'(bs1_reg);
        ahw2_reg  <= ahw1_reg;
        ahh2_reg  <= ahh1_reg;
        bhw2_reg  <= bhw1_reg;
        bhh2_reg  <= bhh1_reg;
    end

    // ---------------- stage 3: projections and magnitudes ----------------
    // |Au.Bu| = |Av.Bv| = c, |Au.Bv| = |Av.Bu| = s
    logic [48:0] dist3_reg [4];
    logic [31:0] c_reg, s_reg;
    logic [30:0] ahw3_reg, ahh3_reg, bhw3_reg, bhh3_reg;

    always_ff @(posedge clk)
    begin
        dist3_reg[0] <= mag50(50'(ac_dx_reg) + 50'(as_dy_reg));
        dist3_reg[1] <= mag50(50'(ac_dy_reg) - 50'(as_dx_reg));
        dist3_reg[2] <= mag50(50'(bc_dx_reg) + 50'(bs_dy_reg));
        dist3_reg[3] <= mag50(50'(bc_dy_reg) - 50'(bs_dx_reg));
        c_reg        <= mag33(33'(cc_reg) + 33'(ss_reg));
        s_reg        <= mag33(33'(sc_reg) - 33'(cs_reg));
        ahw3_reg     <= ahw2_reg;
        ahh3_reg     <= ahh2_reg;
        bhw3_reg     <= bhw2_reg;
        bhh3_reg     <= bhh2_reg;
    end

    // ---------------- stage 4: cross term products ----------------
    logic [48:0] dist4_reg [4];
    logic [62:0] xa_reg [4];   // first cross term per axis
    logic [62:0] xb_reg [4];   // second cross term per axis
    logic [30:0] own4_reg [4];

    always_ff @(posedge clk)
    begin
        dist4_reg   <= dist3_reg;
        xa_reg[0]   <= 63'(c_reg) * 63'(bhw3_reg);
        xb_reg[0]   <= 63'(s_reg) * 63'(bhh3_reg);
        xa_reg[1]   <= 63'(s_reg) * 63'(bhw3_reg);
        xb_reg[1]   <= 63'(c_reg) * 63'(bhh3_reg);
        xa_reg[2]   <= 63'(c_reg) * 63'(ahw3_reg);
        xb_reg[2]   <= 63'(s_reg) * 63'(ahh3_reg);
        xa_reg[3]   <= 63'(s_reg) * 63'(ahw3_reg);
        xb_reg[3]   <= 63'(c_reg) * 63'(ahh3_reg);
        own4_reg[0] <= ahw3_reg;
        own4_reg[1] <= ahh3_reg;
        own4_reg[2] <= bhw3_reg;
        own4_reg[3] <= bhh3_reg;
    end

    // ---------------- stage 5: radius sums ----------------
    logic [48:0] dist5_reg [4];
    logic [63:0] rad_reg [4];

    always_ff @(posedge clk)
    begin
        dist5_reg <= dist4_reg;
        for (int k = 0; k < 4; k++)
        begin
            rad_reg[k] <= (64'(own4_reg[k]) << (2 * ROT_BITS))
                        + 64'(xa_reg[k]) + 64'(xb_reg[k]);
        end
    end

    // ---------------- stage 6: compare and axis pick ----------------
    logic [3:0] sep;
    obb_out_t   res_next;
    obb_out_t   res_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sep[k] = (64'(dist5_reg[k]) << ROT_BITS) > rad_reg[k];
        end
        res_next.overlap = 1'b0;
        priority if (sep[0])
            res_next.separating_axis = AXIS_A_U;
        else if (sep[1])
            res_next.separating_axis = AXIS_A_V;
        else if (sep[2])
            res_next.separating_axis = AXIS_B_U;
        else if (sep[3])
            res_next.separating_axis = AXIS_B_V;
        else
        begin
            res_next.overlap         = 1'b1;
            res_next.separating_axis = AXIS_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // ---------------- valid chain ----------------
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign busy   = 1'b0;
    assign done   = vld_reg[PIPE_DEPTH-1];
    assign result = res_reg;

    // ---------------- assertions ----------------
    a_word_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##6 done)
        else $error("accepted word did not produce a result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##6 !done)
        else $error("result without an accepted word");

    a_overlap_axis_none: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.overlap == (result.separating_axis == AXIS_NONE)))
        else $error("overlap flag and separating axis disagree");

    a_axis_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.separating_axis == AXIS_A_U || result.separating_axis == AXIS_A_V
               || result.separating_axis == AXIS_B_U || result.separating_axis == AXIS_B_V
               || result.separating_axis == AXIS_NONE))
        else $error("separating axis code out of range");

endmodule

@@ sim/oriented_box_overlap_test_core_tb.sv @@
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_core_tb
// Self-checking bench for the 2D oriented box separating axis core. Box pair
// words go in as bursts with random gaps. Each accepted word is scored by a
// local exact-integer model of the four axis tests. The expected verdict is
// matched against the strobed result stream in order.
// ----------------------------------------------------------------------------
module oriented_box_overlap_test_core_tb
    import obb_sat_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE      = 65536;     // 1.0 in Q16.16
    localparam longint DIR_ONE  = 16384;     // 1.0 in Q1.14
    localparam longint DIR_45   = 11585;     // cos 45 deg in Q1.14
    localparam longint EXT_MAX  = 31'h7FFFFFFF;
    localparam int     RANDOM_PAIRS = 1650;
    localparam int     STALL_LIMIT  = 2000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    obb_in_t  boxes = '0;
    logic     done;
    obb_out_t result;

    obb_in_t  pair_queue[$];
    obb_out_t verdict_queue[$];
    int       fail_count = 0;
    int       stall_cycles = 0;
    int       burst_left;
    int       gap_left;

    oriented_box_overlap_test_core uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .boxes  (boxes),
        .done   (done),
        .result (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Verdict model
    // ------------------------------------------------------------------
    function automatic logic [63:0] mag(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Compare at 28 fraction bits beyond the distance format.
    function automatic bit axis_splits(longint px, longint py, longint dx, longint dy,
                                       logic [63:0] own,
                                       longint ux, longint uy, logic [63:0] hu,
                                       longint vx, longint vy, logic [63:0] hv);
        logic [65:0] center_proj;
        logic [65:0] radius_sum;
        center_proj = {2'b00, mag(px * dx + py * dy)} << ROT_BITS;
        radius_sum  = ({2'b00, own} << (2 * ROT_BITS))
                    + mag(px * ux + py * uy) * hu
                    + mag(px * vx + py * vy) * hv;
        return center_proj > radius_sum;
    endfunction

    function automatic obb_out_t sat_verdict(obb_in_t w);
        longint      dx;
        longint      dy;
        longint      ca;
        longint      sa;
        longint      cb;
        longint      sb;
        logic [63:0] ahw;
        logic [63:0] ahh;
        logic [63:0] bhw;
        logic [63:0] bhh;
        obb_out_t    v;
        dx  = longint'($signed(w.a_center_x)) - longint'($signed(w.b_center_x));
        dy  = longint'($signed(w.a_center_y)) - longint'($signed(w.b_center_y));
        ca  = longint'($signed(w.a_cos));
        sa  = longint'($signed(w.a_sin));
        cb  = longint'($signed(w.b_cos));
        sb  = longint'($signed(w.b_sin));
        ahw = 64'(w.a_half_width);
        ahh = 64'(w.a_half_height);
        bhw = 64'(w.b_half_width);
        bhh = 64'(w.b_half_height);
        v.separating_axis = AXIS_NONE;
        if (axis_splits(ca, sa, dx, dy, ahw, cb, sb, bhw, -sb, cb, bhh))
            v.separating_axis = AXIS_A_U;
        else if (axis_splits(-sa, ca, dx, dy, ahh, cb, sb, bhw, -sb, cb, bhh))
            v.separating_axis = AXIS_A_V;
        else if (axis_splits(cb, sb, dx, dy, bhw, ca, sa, ahw, -sa, ca, ahh))
            v.separating_axis = AXIS_B_U;
        else if (axis_splits(-sb, cb, dx, dy, bhh, ca, sa, ahw, -sa, ca, ahh))
            v.separating_axis = AXIS_B_V;
        v.overlap = (v.separating_axis == AXIS_NONE);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic obb_in_t mk_pair(longint ax, longint ay, longint ac, longint as_,
                                        longint ahw, longint ahh,
                                        longint bx, longint by, longint bc, longint bs,
                                        longint bhw, longint bhh);
        obb_in_t w;
        w.a_center_x    = 32'(ax);
        w.a_center_y    = 32'(ay);
        w.a_cos         = 16'(ac);
        w.a_sin         = 16'(as_);
        w.a_half_width  = 31'(ahw);
        w.a_half_height = 31'(ahh);
        w.b_center_x    = 32'(bx);
        w.b_center_y    = 32'(by);
        w.b_cos         = 16'(bc);
        w.b_sin         = 16'(bs);
        w.b_half_width  = 31'(bhw);
        w.b_half_height = 31'(bhh);
        return w;
    endfunction

    task automatic queue_pair(input obb_in_t w);
        pair_queue = {pair_queue, w};
    endtask

    // Roughly uniform in [-span, span].
    function automatic longint rand_span(longint span);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return longint'({1'b0, raw[62:0]} % (2 * span + 1)) - span;
    endfunction

    function automatic longint rand_extent(int k);
        return longint'($urandom_range(0, 32'd1 << k));
    endfunction

    task automatic rand_unit_dir(output longint c, output longint s);
        int ci;
        int si;
        ci = int'($urandom_range(0, 32768)) - 16384;
        si = $rtoi($sqrt(268435456.0 - real'(ci * ci)) + 0.5);
        if ($urandom_range(0, 1))
            si = -si;
        c = ci;
        s = si;
    endtask

    task automatic quarter_dir(input int q, output longint c, output longint s);
        case (q)
            0:       begin c =  DIR_ONE; s = 0;        end
            1:       begin c = 0;        s =  DIR_ONE; end
            2:       begin c = -DIR_ONE; s = 0;        end
            default: begin c = 0;        s = -DIR_ONE; end
        endcase
    endtask

    // Boxes near each other so every axis outcome shows up.
    task automatic make_near_pair(input bit unit_dirs, output obb_in_t w);
        int     k;
        longint ac, as_, bc, bs, ax, ay, span;
        k = $urandom_range(0, 27);
        if (unit_dirs)
        begin
            rand_unit_dir(ac, as_);
            rand_unit_dir(bc, bs);
        end
        else
        begin
            ac  = int'($urandom_range(0, 32768)) - 16384;
            as_ = int'($urandom_range(0, 32768)) - 16384;
            bc  = int'($urandom_range(0, 32768)) - 16384;
            bs  = int'($urandom_range(0, 32768)) - 16384;
        end
        span = longint'(3) << k;
        ax   = rand_span(longint'(1) << 30);
        ay   = rand_span(longint'(1) << 30);
        w = mk_pair(ax, ay, ac, as_, rand_extent(k), rand_extent(k),
                    ax - rand_span(span), ay - rand_span(span), bc, bs,
                    rand_extent(k), rand_extent(k));
    endtask

    // Axis-aligned boxes at exact contact, one LSB inside or one LSB apart.
    task automatic make_contact_pair(output obb_in_t w);
        int     k;
        int     qa;
        int     qb;
        longint ac, as_, bc, bs, ahw, ahh, bhw, bhh, ax, ay;
        longint ext_ax, ext_ay, ext_bx, ext_by, d_main, d_side;
        k  = $urandom_range(0, 27);
        qa = $urandom_range(0, 3);
        qb = $urandom_range(0, 3);
        quarter_dir(qa, ac, as_);
        quarter_dir(qb, bc, bs);
        ahw = rand_extent(k);
        ahh = rand_extent(k);
        bhw = rand_extent(k);
        bhh = rand_extent(k);
        ext_ax = (qa % 2 == 0) ? ahw : ahh;
        ext_ay = (qa % 2 == 0) ? ahh : ahw;
        ext_bx = (qb % 2 == 0) ? bhw : bhh;
        ext_by = (qb % 2 == 0) ? bhh : bhw;
        ax = rand_span(longint'(1) << 29);
        ay = rand_span(longint'(1) << 29);
        if ($urandom_range(0, 1))
        begin
            d_main = ext_ax + ext_bx + int'($urandom_range(0, 2)) - 1;
            d_side = rand_span(ext_ay + ext_by);
            if ($urandom_range(0, 1))
                d_main = -d_main;
            w = mk_pair(ax, ay, ac, as_, ahw, ahh, ax - d_main, ay - d_side,
                        bc, bs, bhw, bhh);
        end
        else
        begin
            d_main = ext_ay + ext_by + int'($urandom_range(0, 2)) - 1;
            d_side = rand_span(ext_ax + ext_bx);
            if ($urandom_range(0, 1))
                d_main = -d_main;
            w = mk_pair(ax, ay, ac, as_, ahw, ahh, ax - d_side, ay - d_main,
                        bc, bs, bhw, bhh);
        end
    endtask

    task automatic make_raw_pair(output obb_in_t w);
        w.a_center_x    = $urandom;
        w.a_center_y    = $urandom;
        w.a_cos         = 16'($urandom);
        w.a_sin         = 16'($urandom);
        w.a_half_width  = 31'($urandom);
        w.a_half_height = 31'($urandom);
        w.b_center_x    = $urandom;
        w.b_center_y    = $urandom;
        w.b_cos         = 16'($urandom);
        w.b_sin         = 16'($urandom);
        w.b_half_width  = 31'($urandom);
        w.b_half_height = 31'($urandom);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            boxes      <= '0;
            burst_left <= 4;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
                verdict_queue = {verdict_queue, sat_verdict(boxes)};
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pair_queue.size() > 0)
                begin
                    boxes <= pair_queue.pop_front();
                    start <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        obb_out_t want;
        if (rst_n && done)
        begin
            if (verdict_queue.size() == 0)
            begin
                fail_count++;
                $error("result word with no pending verdict");
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (result.overlap !== want.overlap)
                begin
                    fail_count++;
                    $error("overlap: expected %0d, got %0d",
                           want.overlap, result.overlap);
                end
                if (result.separating_axis !== want.separating_axis)
                begin
                    fail_count++;
                    $error("separating_axis: expected %0d, got %0d",
                           want.separating_axis, result.separating_axis);
                end
            end
        end
    end

    // Watchdog on cycles with no traffic in either direction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : sequence_main
        obb_in_t w;
        int      kind;

        // point on point
        queue_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // aligned, clearly overlapping
        queue_pair(mk_pair(0, 0, DIR_ONE, 0, 2 * ONE, ONE,
                           ONE, ONE / 2, DIR_ONE, 0, ONE, ONE));
        // touching along x counts as overlap; one LSB further separates on A-u
        queue_pair(mk_pair(0, 0, DIR_ONE, 0, ONE, ONE,
                           2 * ONE, 0, DIR_ONE, 0, ONE, ONE));
        queue_pair(mk_pair(0, 0, DIR_ONE, 0, ONE, ONE,
                           2 * ONE + 1, 0, DIR_ONE, 0, ONE, ONE));
        // separated along y: A-v
        queue_pair(mk_pair(0, 0, DIR_ONE, 0, ONE, ONE,
                           0, -5 * ONE, DIR_ONE, 0, ONE, ONE));
        // diamond against large square: only B axes separate
        queue_pair(mk_pair(0, 0, DIR_45, DIR_45, ONE, ONE,
                           16 * ONE, 0, DIR_ONE, 0, 10 * ONE, 10 * ONE));
        queue_pair(mk_pair(0, 0, DIR_45, DIR_45, ONE, ONE,
                           0, 16 * ONE, DIR_ONE, 0, 10 * ONE, 10 * ONE));
        // field extremes
        queue_pair(mk_pair(32'sh7FFFFFFF, 32'sh7FFFFFFF, -32768, -32768,
                           EXT_MAX, EXT_MAX,
                           -2147483648, -2147483648, -32768, -32768,
                           EXT_MAX, EXT_MAX));
        queue_pair(mk_pair(-2147483648, 32'sh7FFFFFFF, DIR_ONE, -DIR_ONE, 0, 0,
                           32'sh7FFFFFFF, -2147483648, -DIR_ONE, DIR_ONE, 0, 0));
        queue_pair(mk_pair(-2147483648, -2147483648, -32768, 0, 0, EXT_MAX,
                           32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, -32768, EXT_MAX, 0));
        queue_pair(mk_pair(32'sh7FFFFFFF, 0, 32767, 32767, EXT_MAX, EXT_MAX,
                           -2147483648, 0, 32767, -32767, EXT_MAX, EXT_MAX));
        // zero directions project everything to zero
        queue_pair(mk_pair(100 * ONE, -70 * ONE, 0, 0, ONE, ONE,
                           -100 * ONE, 70 * ONE, 0, 0, ONE, ONE));
        // zero-size boxes: separated points on a diagonal
        queue_pair(mk_pair(ONE, ONE, DIR_45, DIR_45, 0, 0,
                           -ONE, -ONE, DIR_ONE, 0, 0, 0));
        // non-unit directions used as given
        queue_pair(mk_pair(0, 0, DIR_ONE, DIR_ONE, ONE, ONE,
                           3 * ONE, 0, 2 * DIR_ONE / 3, -DIR_ONE / 5, ONE, 2 * ONE));
        // segment against segment
        queue_pair(mk_pair(0, 0, DIR_ONE, 0, 4 * ONE, 0,
                           ONE, ONE, 0, DIR_ONE, 4 * ONE, 0));
        queue_pair(mk_pair(0, 0, DIR_ONE, 0, 4 * ONE, 0,
                           0, ONE, DIR_ONE, 0, 4 * ONE, 0));

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 4)
                make_near_pair(1'b1, w);
            else if (kind == 5)
                make_near_pair(1'b0, w);
            else if (kind <= 7)
                make_contact_pair(w);
            else
                make_raw_pair(w);
            queue_pair(w);
        end

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (pair_queue.size() != 0 || start)
            @(negedge clk);
        while (verdict_queue.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/obb_sat_pkg.sv
hw/rtl/oriented_box_overlap_test_core.sv
sim/oriented_box_overlap_test_core_tb.sv
